// ===== hw/rtl/csa_pkg.sv =====
`timescale 1ns / 1ps

package csa_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int VALUE_W    = 64;
	localparam int RESULT_W   = 64;

	// multiplier digit slicing
	localparam int DIG_W  = 16;
	localparam int N_DIG  = (DATA_WIDTH + DIG_W - 1) / DIG_W;
	localparam int MB_W   = N_DIG * DIG_W;
	localparam int PROD_W = DATA_WIDTH + MB_W;
	localparam int PP_W   = DATA_WIDTH + DIG_W;
	localparam int CNT_W  = $clog2(N_DIG + 1);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	localparam logic [DATA_WIDTH-1:0] D_SIGN = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

	localparam logic [2:0] OP_SUM_WRAP  = 3'd0;
	localparam logic [2:0] OP_SUM_CHK   = 3'd1;
	localparam logic [2:0] OP_PROD_WRAP = 3'd2;
	localparam logic [2:0] OP_PROD_CHK  = 3'd3;
	localparam logic [2:0] OP_MIN       = 3'd4;
	localparam logic [2:0] OP_MAX       = 3'd5;

	typedef enum logic [2:0] {
		OPC_NONE,
		OPC_SUM,
		OPC_PROD,
		OPC_MIN,
		OPC_MAX
	} op_class_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_null;
		logic               first;
	} elem_t;

	typedef struct packed {
		logic [RESULT_W-1:0] result;
		logic                result_null;
		logic                overflow;
	} scan_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic               signed_mode;
		logic               start_given;
		logic [VALUE_W-1:0] seed_value;
		logic               null_skip;
	} cfg_t;

	// one classified request on its way to the back end
	typedef struct packed {
		logic                  first;
		logic                  is_null;
		op_class_t             opc;
		logic                  checked;
		logic [DATA_WIDTH-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/cumulative_scan_accumulator.sv =====
`timescale 1ns / 1ps
// Sum, min and max results pass through the queue entry and the scan output register.
// Throughput: one request per cycle for sum, min, max and null requests while scan_stall is low.
// Products use the 64x16 digit multiplier; no new request is taken until one leaves ST_FIN.
// A four-entry queue separates request intake from execution.
// arst_n clears state, queue and configuration to their reset values at once.

module cumulative_scan_accumulator
	import csa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  elem_t              elem,
	input  logic               elem_valid,
	output logic               elem_stall,
	output scan_t              scan,
	output logic               scan_valid,
	input  logic               scan_stall,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam logic [2:0] REG_OPERATION   = 3'd0;
	localparam logic [2:0] REG_SIGNED_MODE = 3'd1;
	localparam logic [2:0] REG_START_GIVEN = 3'd2;
	localparam logic [2:0] REG_SEED_VALUE  = 3'd3;
	localparam logic [2:0] REG_NULL_SKIP   = 3'd4;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       push;
	logic       pop;
	cmd_t       wr_cmd;
	cmd_t       rd_cmd;
	q_stat_t    q_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.operation   <= OP_SUM_WRAP;
			cfg_q.signed_mode <= 1'b1;
			cfg_q.start_given <= 1'b0;
			cfg_q.seed_value  <= '0;
			cfg_q.null_skip   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_OPERATION:   cfg_q.operation   <= pwdata[2:0];
				REG_SIGNED_MODE: cfg_q.signed_mode <= pwdata[0];
				REG_START_GIVEN: cfg_q.start_given <= pwdata[0];
				REG_SEED_VALUE:  cfg_q.seed_value  <= pwdata[VALUE_W-1:0];
				REG_NULL_SKIP:   cfg_q.null_skip   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OPERATION:   prdata = PDATA_W'(cfg_q.operation);
			REG_SIGNED_MODE: prdata = PDATA_W'(cfg_q.signed_mode);
			REG_START_GIVEN: prdata = PDATA_W'(cfg_q.start_given);
			REG_SEED_VALUE:  prdata = PDATA_W'(cfg_q.seed_value);
			REG_NULL_SKIP:   prdata = PDATA_W'(cfg_q.null_skip);
			default:         prdata = '0;
		endcase
	end

	csa_front u_front (
		.elem       (elem),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (wr_cmd)
	);

	csa_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.q_stat (q_stat)
	);

	csa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.cmd        (rd_cmd),
		.pop        (pop),
		.scan       (scan),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall)
	);

endmodule

// ===== hw/rtl/csa_front.sv =====
`timescale 1ns / 1ps

module csa_front
	import csa_pkg::*;
(
	input  elem_t   elem,
	input  logic    elem_valid,
	output logic    elem_stall,
	input  cfg_t    cfg,
	input  q_stat_t q_stat,
	output logic    push,
	output cmd_t    cmd
);

	op_class_t opc;

	always_comb begin
		unique case (cfg.operation) inside
			OP_SUM_WRAP, OP_SUM_CHK:   opc = OPC_SUM;
			OP_PROD_WRAP, OP_PROD_CHK: opc = OPC_PROD;
			OP_MIN:                    opc = OPC_MIN;
			OP_MAX:                    opc = OPC_MAX;
			default:                   opc = OPC_NONE;
		endcase
	end

	assign elem_stall = q_stat.full;
	assign push       = elem_valid && !q_stat.full;

	assign cmd.first   = elem.first;
	assign cmd.is_null = elem.is_null;
	assign cmd.opc     = opc;
	assign cmd.checked = (cfg.operation == OP_SUM_CHK) || (cfg.operation == OP_PROD_CHK);
	assign cmd.value   = elem.value[DATA_WIDTH-1:0];

endmodule

// ===== hw/rtl/csa_fifo.sv =====
`timescale 1ns / 1ps

module csa_fifo
	import csa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wr_cmd,
	input  logic    pop,
	output cmd_t    rd_cmd,
	output q_stat_t q_stat
);

	cmd_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_cmd       = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (Q_AW + 1)'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

// ===== hw/rtl/csa_back.sv =====
`timescale 1ns / 1ps

module csa_back
	import csa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  q_stat_t q_stat,
	input  cmd_t    cmd,
	output logic    pop,
	output scan_t   scan,
	output logic    scan_valid,
	input  logic    scan_stall
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [DATA_WIDTH-1:0] run_q;
	logic                  null_q;
	logic                  err_q;
	logic [DATA_WIDTH-1:0] ma_q;
	logic [MB_W-1:0]       mb_q;
	logic [PROD_W-1:0]     prod_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  chk_q;
	scan_t                 scan_q;
	logic                  scan_valid_q;

	logic                  out_free;
	logic [DATA_WIDTH-1:0] ident;
	logic [DATA_WIDTH-1:0] acc_eff;
	logic                  null_eff;
	logic                  err_eff;
	logic                  res_null;
	logic                  null_new;
	logic                  is_mul;
	logic [DATA_WIDTH:0]   sum_w;
	logic [DATA_WIDTH-1:0] fold_val;
	logic                  fold_ovf;
	logic [DATA_WIDTH-1:0] ma_nx;
	logic [DATA_WIDTH-1:0] mb_nx;
	logic [PP_W-1:0]       pp;
	logic [PP_W-1:0]       pp_sum;
	logic [PROD_W-1:0]     prod_nx;
	logic [DATA_WIDTH-1:0] lo;
	logic                  hi_nz;
	logic [DATA_WIDTH-1:0] prod_res;
	logic                  prod_ovf;

	function automatic logic lt_f(
		input logic [DATA_WIDTH-1:0] a,
		input logic [DATA_WIDTH-1:0] b,
		input logic                  sg
	);
		logic [DATA_WIDTH-1:0] fa;
		logic [DATA_WIDTH-1:0] fb;
		fa = sg ? (a ^ D_SIGN) : a;
		fb = sg ? (b ^ D_SIGN) : b;
		return fa < fb;
	endfunction

	assign out_free = !scan_valid_q || !scan_stall;

	always_comb begin
		unique case (cmd.opc)
			OPC_PROD: ident = DATA_WIDTH'(1);
			OPC_MIN:  ident = cfg.signed_mode ? ~D_SIGN : '1;
			OPC_MAX:  ident = cfg.signed_mode ? D_SIGN : '0;
			default:  ident = '0;
		endcase
	end

	// state as seen by this request, after a possible reload
	assign acc_eff  = cmd.first ? (cfg.start_given ? cfg.seed_value[DATA_WIDTH-1:0] : ident)
	                            : run_q;
	assign null_eff = cmd.first ? 1'b0 : null_q;
	assign err_eff  = cmd.first ? 1'b0 : err_q;
	assign res_null = cmd.is_null || (!cfg.null_skip && null_eff);
	assign null_new = null_eff || (cmd.is_null && !cfg.null_skip);
	assign is_mul   = !res_null && (cmd.opc == OPC_PROD);

	assign sum_w = {1'b0, acc_eff} + {1'b0, cmd.value};

	always_comb begin
		fold_val = acc_eff;
		fold_ovf = 1'b0;
		case (cmd.opc)
			OPC_SUM: begin
				fold_val = sum_w[DATA_WIDTH-1:0];
				if (cfg.signed_mode) begin
					fold_ovf = (acc_eff[DATA_WIDTH-1] == cmd.value[DATA_WIDTH-1])
					        && (sum_w[DATA_WIDTH-1] != acc_eff[DATA_WIDTH-1]);
				end else begin
					fold_ovf = sum_w[DATA_WIDTH];
				end
			end
			OPC_MIN: fold_val = lt_f(cmd.value, acc_eff, cfg.signed_mode) ? cmd.value : acc_eff;
			OPC_MAX: fold_val = lt_f(acc_eff, cmd.value, cfg.signed_mode) ? cmd.value : acc_eff;
			default: fold_val = acc_eff;
		endcase
	end

	// magnitudes for the digit-serial multiply
	assign ma_nx = (cfg.signed_mode && acc_eff[DATA_WIDTH-1]) ? -acc_eff : acc_eff;
	assign mb_nx = (cfg.signed_mode && cmd.value[DATA_WIDTH-1]) ? -cmd.value : cmd.value;

	assign pp      = PP_W'(ma_q) * PP_W'(mb_q[DIG_W-1:0]);
	assign pp_sum  = PP_W'(prod_q[PROD_W-1:MB_W]) + pp;
	assign prod_nx = PROD_W'({pp_sum, prod_q[MB_W-1:0]} >> DIG_W);

	assign lo       = prod_q[DATA_WIDTH-1:0];
	assign hi_nz    = |prod_q[PROD_W-1:DATA_WIDTH];
	assign prod_res = neg_q ? -lo : lo;
	assign prod_ovf = cfg.signed_mode ? (hi_nz || (lo > (neg_q ? D_SIGN : ~D_SIGN))) : hi_nz;

	assign pop = (state_q == ST_IDLE) && !q_stat.empty && (out_free || is_mul);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			run_q        <= '0;
			null_q       <= 1'b0;
			err_q        <= 1'b0;
			ma_q         <= '0;
			mb_q         <= '0;
			prod_q       <= '0;
			cnt_q        <= '0;
			neg_q        <= 1'b0;
			chk_q        <= 1'b0;
			scan_q       <= '0;
			scan_valid_q <= 1'b0;
		end else begin
			if (!scan_stall) begin
				scan_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						null_q <= null_new;
						if (is_mul) begin
							run_q   <= acc_eff;
							err_q   <= err_eff;
							ma_q    <= ma_nx;
							mb_q    <= MB_W'(mb_nx);
							prod_q  <= '0;
							cnt_q   <= '0;
							neg_q   <= cfg.signed_mode
							        && (acc_eff[DATA_WIDTH-1] ^ cmd.value[DATA_WIDTH-1]);
							chk_q   <= cmd.checked;
							state_q <= ST_MUL;
						end else begin
							run_q <= res_null ? acc_eff : fold_val;
							err_q <= err_eff || (!res_null && fold_ovf && cmd.checked);
							scan_q.result      <= res_null ? '0 : RESULT_W'(fold_val);
							scan_q.result_null <= res_null;
							scan_q.overflow    <= err_eff || (!res_null && fold_ovf && cmd.checked);
							scan_valid_q       <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					prod_q <= prod_nx;
					mb_q   <= mb_q >> DIG_W;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(N_DIG - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						run_q              <= prod_res;
						err_q              <= err_q || (prod_ovf && chk_q);
						scan_q.result      <= RESULT_W'(prod_res);
						scan_q.result_null <= 1'b0;
						scan_q.overflow    <= err_q || (prod_ovf && chk_q);
						scan_valid_q       <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign scan       = scan_q;
	assign scan_valid = scan_valid_q;

`ifndef SYNTH
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("request taken while multiply in progress");

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid_q && scan_q.result_null) |-> (scan_q.result == '0))
		else $error("null result carries data");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && cnt_q == CNT_W'(N_DIG - 1)) |=> (state_q == ST_FIN))
		else $error("multiply did not finish after last digit");
`endif

endmodule
